[rtl/allm_pkg.sv]
// ----------------------------------------------------------------------------
// allm_pkg
// Shared types and constants of the array-backed doubly linked list manager.
// ----------------------------------------------------------------------------
`default_nettype none

package allm_pkg;

   // Fixed widths of the item fields on the two channels.
   localparam int OP_W         = 2;
   localparam int STATUS_W     = 2;
   localparam int VALUE_PORT_W = 32;
   localparam int SLOT_PORT_W  = 6;
   localparam int COUNT_PORT_W = 7;

   // Widest row of the occupancy map, in slots.
   localparam int OCC_ROW_MAX = 32;

   // Operation codes of an input item.
   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_READ   = 2'd2
   } op_type;

   // Status codes of a result item.
   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 2'd0,
      ST_FULL         = 2'd1,
      ST_NOT_OCCUPIED = 2'd2
   } status_type;

   // Strobes into the node memory; one address serves the read and the writes.
   typedef struct packed {
      logic rd_en;
      logic wr_value;
      logic wr_next;
      logic wr_prev;
   } node_ctl_type;

   // Strobes into the occupancy map.
   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } occ_ctl_type;

endpackage

`default_nettype wire

[rtl/array_linked_list_manager.sv]
// ----------------------------------------------------------------------------
// array_linked_list_manager
// Doubly linked list in a fixed array of slots, driven by a sequencer.
// ----------------------------------------------------------------------------
// Each req_ item is an insert at the tail, a remove of a slot or a read of a
// slot; each gives exactly one rsp_ item with the status, the slot taken by
// an insert or the successor of a read slot, the value read or removed, and
// the head slot, element count and empty flag after it. Values and links
// live in a node memory, occupancy in a bitmap memory of rows of up to 32
// slots; both have a registered read. A full list, a slot out of range or
// an undefined operation goes straight to the result; a read and a remove
// first read the slot's node and occupancy row, and a remove of a slot with
// two neighbors then rewrites the successor's back link as well. An insert
// scans the occupancy rows from the search hint, row by row, for a free
// slot, then writes the old tail's forward link unless the list was empty.
// The sequencer handles one item at a time, so a new item is taken only
// when the previous one has reached the result register.
// A result waits in the output register while rsp_ready is low; the next
// item is still taken, and its result waits in the sequencer until the
// register is free. Reset empties the list at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module array_linked_list_manager
   import allm_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire logic [OP_W-1:0]         req_op,
   input  wire logic [VALUE_PORT_W-1:0] req_item_value,
   input  wire logic [SLOT_PORT_W-1:0]  req_slot,

   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic      [STATUS_W-1:0]     rsp_status,
   output logic      [SLOT_PORT_W-1:0]  rsp_result_slot,
   output logic                         rsp_has_next,
   output logic      [VALUE_PORT_W-1:0] rsp_value_out,
   output logic      [SLOT_PORT_W-1:0]  rsp_head_slot,
   output logic      [COUNT_PORT_W-1:0] rsp_element_count,
   output logic                         rsp_is_empty
);

   localparam int SLOT_W    = $clog2(CAPACITY);
   localparam int COUNT_W   = $clog2(CAPACITY + 1);
   localparam int ROW_W     = (CAPACITY < OCC_ROW_MAX) ? 2 ** SLOT_W : OCC_ROW_MAX;
   localparam int ROW_BIT_W = $clog2(ROW_W);
   localparam int ROWS      = (CAPACITY + ROW_W - 1) / ROW_W;
   localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_INS_LINK,
      S_CHECK,
      S_RM_PREV,
      S_RESPOND
   } state_type;

   // Sequencer state and list registers.
   state_type              state_ff, state_in;
   op_type                 op_ff, op_in;
   logic [VALUE_WIDTH-1:0] val_ff, val_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [SLOT_W-1:0]      head_ff, head_in;
   logic [SLOT_W-1:0]      tail_ff, tail_in;
   logic [SLOT_W-1:0]      free_ff, free_in;
   logic [SLOT_W-1:0]      link_p_ff, link_p_in;
   logic [SLOT_W-1:0]      link_n_ff, link_n_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [COUNT_W-1:0]     hint_ff, hint_in;
   logic [ROW_AW-1:0]      srow_ff, srow_in;

   // Result of the item in work.
   status_type             res_status_ff, res_status_in;
   logic [SLOT_PORT_W-1:0] res_slot_ff, res_slot_in;
   logic                   res_has_next_ff, res_has_next_in;
   logic [VALUE_PORT_W-1:0] res_value_ff, res_value_in;

   // Output register.
   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [SLOT_PORT_W-1:0]  rsp_result_slot_ff, rsp_result_slot_in;
   logic                    rsp_has_next_ff, rsp_has_next_in;
   logic [VALUE_PORT_W-1:0] rsp_value_out_ff, rsp_value_out_in;
   logic [SLOT_PORT_W-1:0]  rsp_head_slot_ff, rsp_head_slot_in;
   logic [COUNT_PORT_W-1:0] rsp_element_count_ff, rsp_element_count_in;
   logic                    rsp_is_empty_ff, rsp_is_empty_in;

   // Memory ports.
   node_ctl_type           node_ctl;
   logic [SLOT_W-1:0]      node_addr;
   logic [VALUE_WIDTH-1:0] node_wr_value;
   logic [SLOT_W-1:0]      node_wr_link;
   logic [VALUE_WIDTH-1:0] node_rd_value;
   logic [SLOT_W-1:0]      node_rd_next;
   logic [SLOT_W-1:0]      node_rd_prev;

   occ_ctl_type            occ_ctl;
   logic [ROW_AW-1:0]      occ_row;
   logic [ROW_W-1:0]       occ_wr_data;
   logic [ROW_W-1:0]       occ_rd_data;

   // Decoded slot numbers and search results.
   logic [SLOT_W-1:0]      req_slot_idx;
   logic                   req_in_range;
   logic [ROW_BIT_W-1:0]   slot_bit;
   logic                   slot_occupied;
   logic [ROW_W-1:0]       avail;
   logic                   found;
   logic [ROW_BIT_W-1:0]   found_bit;
   logic [SLOT_W-1:0]      found_slot;
   logic                   accept;

   allm_node_mem #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH),
      .SLOT_W      (SLOT_W)
   ) u_node_mem (
      .clock    (clock),
      .ctl      (node_ctl),
      .addr     (node_addr),
      .wr_value (node_wr_value),
      .wr_link  (node_wr_link),
      .rd_value (node_rd_value),
      .rd_next  (node_rd_next),
      .rd_prev  (node_rd_prev)
   );

   allm_occ_map #(
      .ROWS   (ROWS),
      .ROW_W  (ROW_W),
      .ROW_AW (ROW_AW)
   ) u_occ_map (
      .clock   (clock),
      .reset   (reset),
      .ctl     (occ_ctl),
      .row     (occ_row),
      .wr_data (occ_wr_data),
      .rd_data (occ_rd_data)
   );

   assign req_ready    = (state_ff == S_IDLE) && !reset;
   assign accept       = req_valid && req_ready;
   assign req_slot_idx = SLOT_W'(req_slot);
   assign req_in_range = int'(req_slot) < CAPACITY;
   assign slot_bit     = slot_ff[ROW_BIT_W-1:0];
   assign slot_occupied = occ_rd_data[slot_bit];

   // Free slots in the scanned row: not occupied, not below the search
   // hint and inside the capacity.
   always_comb begin
      int g;
      g = 0;
      for (int b = 0; b < ROW_W; b++) begin
         g = int'(srow_ff) * ROW_W + b;
         avail[b] = !occ_rd_data[b] && (g >= int'(hint_ff)) && (g < CAPACITY);
      end
   end

   // Lowest free slot of the row.
   always_comb begin
      found_bit = '0;
      for (int b = ROW_W - 1; b >= 0; b--) begin
         if (avail[b]) begin
            found_bit = ROW_BIT_W'(b);
         end
      end
   end

   assign found      = |avail;
   assign found_slot = SLOT_W'({srow_ff, found_bit});

   // Sequencer: next state, memory strobes and register updates.
   always_comb begin
      state_in        = state_ff;
      op_in           = op_ff;
      val_in          = val_ff;
      slot_in         = slot_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      free_in         = free_ff;
      link_p_in       = link_p_ff;
      link_n_in       = link_n_ff;
      count_in        = count_ff;
      hint_in         = hint_ff;
      srow_in         = srow_ff;
      res_status_in   = res_status_ff;
      res_slot_in     = res_slot_ff;
      res_has_next_in = res_has_next_ff;
      res_value_in    = res_value_ff;

      node_ctl      = '0;
      node_addr     = slot_ff;
      node_wr_value = val_ff;
      node_wr_link  = tail_ff;
      occ_ctl       = '0;
      occ_row       = ROW_AW'(slot_ff >> ROW_BIT_W);
      occ_wr_data   = occ_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in           = op_type'(req_op);
               val_in          = VALUE_WIDTH'(req_item_value);
               slot_in         = req_slot_idx;
               res_status_in   = ST_OK;
               res_slot_in     = '0;
               res_has_next_in = 1'b0;
               res_value_in    = '0;
               state_in        = S_RESPOND;
               case (op_type'(req_op))
                  OP_INSERT: begin
                     if (int'(count_ff) == CAPACITY) begin
                        res_status_in = ST_FULL;
                     end else begin
                        srow_in       = ROW_AW'(hint_ff >> ROW_BIT_W);
                        occ_row       = ROW_AW'(hint_ff >> ROW_BIT_W);
                        occ_ctl.rd_en = 1'b1;
                        state_in      = S_SEARCH;
                     end
                  end
                  OP_REMOVE, OP_READ: begin
                     if (!req_in_range) begin
                        res_status_in = ST_NOT_OCCUPIED;
                     end else begin
                        node_addr      = req_slot_idx;
                        node_ctl.rd_en = 1'b1;
                        occ_row        = ROW_AW'(req_slot_idx >> ROW_BIT_W);
                        occ_ctl.rd_en  = 1'b1;
                        state_in       = S_CHECK;
                     end
                  end
                  default: begin
                     // Undefined operation: report the list as it stands.
                     res_status_in = ST_OK;
                  end
               endcase
            end
         end

         S_SEARCH: begin
            if (found) begin
               // Claim the slot, store the value and link it behind the tail.
               occ_row           = srow_ff;
               occ_wr_data       = occ_rd_data | (ROW_W'(1) << found_bit);
               occ_ctl.wr_en     = 1'b1;
               node_addr         = found_slot;
               node_wr_value     = val_ff;
               node_wr_link      = tail_ff;
               node_ctl.wr_value = 1'b1;
               node_ctl.wr_prev  = 1'b1;
               free_in           = found_slot;
               hint_in           = COUNT_W'(found_slot) + COUNT_W'(1);
               res_slot_in       = SLOT_PORT_W'(found_slot);
               if (count_ff == '0) begin
                  head_in  = found_slot;
                  tail_in  = found_slot;
                  count_in = COUNT_W'(count_ff + 1'b1);
                  state_in = S_RESPOND;
               end else begin
                  state_in = S_INS_LINK;
               end
            end else begin
               srow_in       = ROW_AW'(srow_ff + 1'b1);
               occ_row       = ROW_AW'(srow_ff + 1'b1);
               occ_ctl.rd_en = 1'b1;
            end
         end

         S_INS_LINK: begin
            // The old tail gets the new slot as successor.
            node_addr        = tail_ff;
            node_wr_link     = free_ff;
            node_ctl.wr_next = 1'b1;
            tail_in          = free_ff;
            count_in         = COUNT_W'(count_ff + 1'b1);
            state_in         = S_RESPOND;
         end

         S_CHECK: begin
            state_in = S_RESPOND;
            if (!slot_occupied) begin
               res_status_in = ST_NOT_OCCUPIED;
            end else if (op_ff == OP_READ) begin
               res_value_in = VALUE_PORT_W'(node_rd_value);
               if (slot_ff != tail_ff) begin
                  res_has_next_in = 1'b1;
                  res_slot_in     = SLOT_PORT_W'(node_rd_next);
               end
            end else begin
               // Remove: free the slot and unlink it.
               res_value_in  = VALUE_PORT_W'(node_rd_value);
               occ_wr_data   = occ_rd_data & ~(ROW_W'(1) << slot_bit);
               occ_ctl.wr_en = 1'b1;
               if (COUNT_W'(slot_ff) < hint_ff) begin
                  hint_in = COUNT_W'(slot_ff);
               end
               count_in = COUNT_W'(count_ff - 1'b1);
               if (count_ff <= COUNT_W'(1)) begin
                  head_in = '0;
                  tail_in = '0;
               end else if (slot_ff == head_ff) begin
                  head_in = node_rd_next;
               end else if (slot_ff == tail_ff) begin
                  tail_in = node_rd_prev;
               end else begin
                  node_addr        = node_rd_prev;
                  node_wr_link     = node_rd_next;
                  node_ctl.wr_next = 1'b1;
                  link_p_in        = node_rd_prev;
                  link_n_in        = node_rd_next;
                  state_in         = S_RM_PREV;
               end
            end
         end

         S_RM_PREV: begin
            // The successor now points back to the predecessor.
            node_addr        = link_n_ff;
            node_wr_link     = link_p_ff;
            node_ctl.wr_prev = 1'b1;
            state_in         = S_RESPOND;
         end

         S_RESPOND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loads the finished result when it is free.
   always_comb begin
      rsp_valid_in         = rsp_valid_ff;
      rsp_status_in        = rsp_status_ff;
      rsp_result_slot_in   = rsp_result_slot_ff;
      rsp_has_next_in      = rsp_has_next_ff;
      rsp_value_out_in     = rsp_value_out_ff;
      rsp_head_slot_in     = rsp_head_slot_ff;
      rsp_element_count_in = rsp_element_count_ff;
      rsp_is_empty_in      = rsp_is_empty_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (state_ff == S_RESPOND && (!rsp_valid_ff || rsp_ready)) begin
         rsp_valid_in         = 1'b1;
         rsp_status_in        = res_status_ff;
         rsp_result_slot_in   = res_slot_ff;
         rsp_has_next_in      = res_has_next_ff;
         rsp_value_out_in     = res_value_ff;
         rsp_head_slot_in     = (count_ff == '0) ? '0 : SLOT_PORT_W'(head_ff);
         rsp_element_count_in = COUNT_PORT_W'(count_ff);
         rsp_is_empty_in      = (count_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= S_IDLE;
         op_ff                <= OP_INSERT;
         val_ff               <= '0;
         slot_ff              <= '0;
         head_ff              <= '0;
         tail_ff              <= '0;
         free_ff              <= '0;
         link_p_ff            <= '0;
         link_n_ff            <= '0;
         count_ff             <= '0;
         hint_ff              <= '0;
         srow_ff              <= '0;
         res_status_ff        <= ST_OK;
         res_slot_ff          <= '0;
         res_has_next_ff      <= 1'b0;
         res_value_ff         <= '0;
         rsp_valid_ff         <= 1'b0;
         rsp_status_ff        <= ST_OK;
         rsp_result_slot_ff   <= '0;
         rsp_has_next_ff      <= 1'b0;
         rsp_value_out_ff     <= '0;
         rsp_head_slot_ff     <= '0;
         rsp_element_count_ff <= '0;
         rsp_is_empty_ff      <= 1'b1;
      end else begin
         state_ff             <= state_in;
         op_ff                <= op_in;
         val_ff               <= val_in;
         slot_ff              <= slot_in;
         head_ff              <= head_in;
         tail_ff              <= tail_in;
         free_ff              <= free_in;
         link_p_ff            <= link_p_in;
         link_n_ff            <= link_n_in;
         count_ff             <= count_in;
         hint_ff              <= hint_in;
         srow_ff              <= srow_in;
         res_status_ff        <= res_status_in;
         res_slot_ff          <= res_slot_in;
         res_has_next_ff      <= res_has_next_in;
         res_value_ff         <= res_value_in;
         rsp_valid_ff         <= rsp_valid_in;
         rsp_status_ff        <= rsp_status_in;
         rsp_result_slot_ff   <= rsp_result_slot_in;
         rsp_has_next_ff      <= rsp_has_next_in;
         rsp_value_out_ff     <= rsp_value_out_in;
         rsp_head_slot_ff     <= rsp_head_slot_in;
         rsp_element_count_ff <= rsp_element_count_in;
         rsp_is_empty_ff      <= rsp_is_empty_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_result_slot   = rsp_result_slot_ff;
   assign rsp_has_next      = rsp_has_next_ff;
   assign rsp_value_out     = rsp_value_out_ff;
   assign rsp_head_slot     = rsp_head_slot_ff;
   assign rsp_element_count = rsp_element_count_ff;
   assign rsp_is_empty      = rsp_is_empty_ff;

   // A full report only comes with a list at capacity.
   a_full_at_capacity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_element_count == COUNT_PORT_W'(CAPACITY)))
      else $error("full status reported below capacity");

   // An empty list keeps head and tail at slot zero.
   a_empty_pointers: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0 && tail_ff == '0))
      else $error("empty list with nonzero head or tail");

   // The free-slot search only runs while a free slot exists.
   a_search_has_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (int'(count_ff) < CAPACITY))
      else $error("free-slot search started on a full list");

endmodule

`default_nettype wire

[rtl/allm_node_mem.sv]
// ----------------------------------------------------------------------------
// allm_node_mem
// Slot storage: value, successor link and predecessor link of every slot,
// with a write enable per field and a registered read of all three.
// ----------------------------------------------------------------------------
`default_nettype none

module allm_node_mem
   import allm_pkg::*;
#(
   parameter int CAPACITY    = 64,
   parameter int VALUE_WIDTH = 32,
   parameter int SLOT_W      = 6
) (
   input  wire logic                   clock,
   input  wire node_ctl_type           ctl,
   input  wire logic [SLOT_W-1:0]      addr,
   input  wire logic [VALUE_WIDTH-1:0] wr_value,
   input  wire logic [SLOT_W-1:0]      wr_link,
   output logic      [VALUE_WIDTH-1:0] rd_value,
   output logic      [SLOT_W-1:0]      rd_next,
   output logic      [SLOT_W-1:0]      rd_prev
);

   logic [VALUE_WIDTH-1:0] value_mem [CAPACITY];
   logic [SLOT_W-1:0]      next_mem  [CAPACITY];
   logic [SLOT_W-1:0]      prev_mem  [CAPACITY];

   logic [VALUE_WIDTH-1:0] rd_value_ff;
   logic [SLOT_W-1:0]      rd_next_ff;
   logic [SLOT_W-1:0]      rd_prev_ff;

   // Field writes; the successor and predecessor never change in one cycle.
   always_ff @(posedge clock) begin
      if (ctl.wr_value) begin
         value_mem[addr] <= wr_value;
      end
      if (ctl.wr_next) begin
         next_mem[addr] <= wr_link;
      end
      if (ctl.wr_prev) begin
         prev_mem[addr] <= wr_link;
      end
   end

   // Registered read of the whole node.
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_value_ff <= value_mem[addr];
         rd_next_ff  <= next_mem[addr];
         rd_prev_ff  <= prev_mem[addr];
      end
   end

   assign rd_value = rd_value_ff;
   assign rd_next  = rd_next_ff;
   assign rd_prev  = rd_prev_ff;

endmodule

`default_nettype wire

[rtl/allm_occ_map.sv]
// ----------------------------------------------------------------------------
// allm_occ_map
// Occupancy bitmap kept in rows of slots. Each row has a valid bit that
// reset clears, and a row that was never written reads as all free.
// ----------------------------------------------------------------------------
`default_nettype none

module allm_occ_map
   import allm_pkg::*;
#(
   parameter int ROWS   = 2,
   parameter int ROW_W  = 32,
   parameter int ROW_AW = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire occ_ctl_type       ctl,
   input  wire logic [ROW_AW-1:0] row,
   input  wire logic [ROW_W-1:0]  wr_data,
   output logic      [ROW_W-1:0]  rd_data
);

   logic [ROW_W-1:0] row_mem [ROWS];
   logic [ROWS-1:0]  row_valid_ff;
   logic [ROWS-1:0]  row_valid_in;
   logic [ROW_W-1:0] rd_data_ff;
   logic             rd_valid_ff;
   logic             rd_valid_in;

   // Row valid bits follow the writes.
   always_comb begin
      row_valid_in = row_valid_ff;
      if (ctl.wr_en) begin
         row_valid_in[row] = 1'b1;
      end
   end

   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (ctl.rd_en) begin
         rd_valid_in = row_valid_ff[row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rd_valid_ff  <= rd_valid_in;
      end
   end

   // Row storage with a registered read.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         row_mem[row] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= row_mem[row];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire
